[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset qualification
`define GHASH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// check at every edge, reset included
`define GHASH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ghash_pkg.sv]
package ghash_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned BLOCK_W = 2 * HALF_W;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] ghash_cfg_idx_t;

    localparam ghash_cfg_idx_t CFG_KEY_HIGH = 1'b0;
    localparam ghash_cfg_idx_t CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
        logic              first_block;
        logic              last_block;
    } ghash_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] tag_high;
        logic [HALF_W-1:0] tag_low;
    } ghash_out_t;

    typedef struct packed {
        logic       valid;
        ghash_out_t tag;
    } ghash_res_t;

    function automatic logic [BLOCK_W-1:0] bit_reverse(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[i] = v[BLOCK_W-1-i];
        end
        return r;
    endfunction

endpackage

[src/ghash_accumulator.sv]
// GHASH accumulator over GF(2^128), GCM bit order.
// Key: write hash_key_high (index 0) and hash_key_low (index 1) on the cfg
// channel while no word is in flight; cfg_ready is always high.
// Input: one 128-bit data block per s_ word, with first_block clearing the
// digest before the block is absorbed and last_block asking for the tag.
// Output: one m_ word per last_block word, carrying the updated digest.
// A tag passes the input register and then the output register to m_.
// Throughput: one input word per cycle while s_ready is high, set by a
// combinational carry-less multiply and reduction from input to digest register.
// The digest is kept after a tag; start each message with first_block.
// Reset (aresetn low, synchronous) clears the key, the digest and all valid
// flags. When m_ready is low the tag holds in the output register; words
// without last_block still flow, and a further last_block word waits in the
// input register, which then drops s_ready until the tag is taken.
module ghash_accumulator import ghash_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ghash_in_t           s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ghash_out_t          m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ghash_cfg_idx_t      cfg_index,
    input  logic [HALF_W-1:0]   cfg_data
);

`include "assert_macros.svh"

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    ghash_out_t        m_data_reg;
    ghash_res_t        res;
    logic              res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    ghash_digest u_digest (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .hash_key  ({key_high_reg, key_low_reg}),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_ready) begin
            m_data_reg <= res.tag;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GHASH_ASSERT(a_tag_loaded, aclk, aresetn, (res.valid && res_ready) |=> (m_valid && m_data == $past(res.tag)), "tag not loaded into output register")
    `GHASH_ASSERT(a_tag_drained, aclk, aresetn, (m_valid && m_ready && !res.valid) |=> !m_valid, "output word repeated after hand-off")
    `GHASH_ASSERT_ALWAYS(a_reset_idle, aclk, !$past(aresetn) |-> (!m_valid && s_ready), "block not idle after reset")

endmodule

[src/ghash_gf_mul.sv]
module ghash_gf_mul import ghash_pkg::*; (
    input  logic [BLOCK_W-1:0] x,
    input  logic [BLOCK_W-1:0] h,
    output logic [BLOCK_W-1:0] z
);

    localparam int unsigned PROD_W = 2 * BLOCK_W - 1;
    localparam int unsigned HI_W   = BLOCK_W - 1;
    localparam int unsigned FOLD_W = HI_W + 7;
    localparam int unsigned OV_W   = FOLD_W - BLOCK_W;

    logic [BLOCK_W-1:0] a;
    logic [BLOCK_W-1:0] b;
    logic [PROD_W-1:0]  prod;
    logic [HI_W-1:0]    hi;
    logic [FOLD_W-1:0]  fold;
    logic [OV_W-1:0]    ov;
    logic [BLOCK_W-1:0] ov_fold;
    logic [BLOCK_W-1:0] red;

    // coefficient i of the field element sits at vector bit 127-i
    assign a = bit_reverse(x);
    assign b = bit_reverse(h);

    // carry-less product: XOR of independent partial products
    always_comb begin
        prod = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            if (a[i]) begin
                prod = prod ^ (PROD_W'(b) << i);
            end
        end
    end

    // reduce by x^128 = x^7 + x^2 + x + 1 in two folds
    assign hi   = prod[PROD_W-1:BLOCK_W];
    assign fold = FOLD_W'(hi) ^ (FOLD_W'(hi) << 1) ^ (FOLD_W'(hi) << 2)
                ^ (FOLD_W'(hi) << 7);
    assign ov   = fold[FOLD_W-1:BLOCK_W];
    assign ov_fold = BLOCK_W'(ov) ^ (BLOCK_W'(ov) << 1) ^ (BLOCK_W'(ov) << 2)
                   ^ (BLOCK_W'(ov) << 7);
    assign red  = prod[BLOCK_W-1:0] ^ fold[BLOCK_W-1:0] ^ ov_fold;

    assign z = bit_reverse(red);

endmodule

[src/ghash_digest.sv]
module ghash_digest import ghash_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ghash_in_t          s_data,
    input  logic [BLOCK_W-1:0] hash_key,
    output ghash_res_t         res,
    input  logic               res_ready
);

    logic               in_valid_reg;
    logic               in_valid_next;
    ghash_in_t          in_reg;
    logic [BLOCK_W-1:0] digest_reg;
    logic [BLOCK_W-1:0] digest_next;
    logic [BLOCK_W-1:0] mul_in;
    logic [BLOCK_W-1:0] product;
    logic               advance;

    // hold a last word until the output side can take its tag
    assign advance = in_valid_reg && (!in_reg.last_block || res_ready);
    assign s_ready = !in_valid_reg || advance;

    assign mul_in = (in_reg.first_block ? '0 : digest_reg)
                  ^ {in_reg.block_high, in_reg.block_low};

    ghash_gf_mul u_mul (
        .x (mul_in),
        .h (hash_key),
        .z (product)
    );

    assign digest_next = advance ? product : digest_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            digest_reg   <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            digest_reg   <= digest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    assign res.valid        = in_valid_reg && in_reg.last_block;
    assign res.tag.tag_high = product[BLOCK_W-1:HALF_W];
    assign res.tag.tag_low  = product[HALF_W-1:0];

endmodule
